@@ rtl/ilist_pkg.sv @@
package ilist_pkg;

    localparam int POS_W    = 7;
    localparam int READ_W   = 32;
    localparam int STATUS_W = 2;
    localparam int REQ_W    = 3;
    localparam int GRP      = 16;

    localparam logic [REQ_W-1:0] REQ_GET        = 3'd0;
    localparam logic [REQ_W-1:0] REQ_INS_HEAD   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_INS_TAIL   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_INS_BEFORE = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DELETE     = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic ins;
        logic del;
    } t_cell_cmd;

endpackage

@@ rtl/indexed_list_engine_top.sv @@
// channel | direction | handshake          | payload
// request | in        | i_valid / o_stall  | i_req_type, i_position, i_item_value
// result  | out       | o_valid / i_stall  | o_read_value, o_status, o_length
//
// Edits land in the cell chain at the transfer edge; their result is registered at that same edge.
// A get reads the selected cell through a two-level registered OR tree (S_GATHER, then S_FINAL).
// One request is in flight at a time; o_stall stays high until the result transfers.
// i_rst_n (synchronous) clears the count and the control; list contents are kept.
// i_stall holds the result registers unchanged.
module indexed_list_engine_top #(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [ilist_pkg::REQ_W-1:0]          i_req_type,
    input  logic [ilist_pkg::POS_W-1:0]          i_position,
    input  logic signed [31:0]                   i_item_value,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [ilist_pkg::READ_W-1:0]  o_read_value,
    output logic [ilist_pkg::STATUS_W-1:0]       o_status,
    output logic [$clog2(CAPACITY+1)-1:0]        o_length
);
    import ilist_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam int NGRP = (CAPACITY + GRP - 1) / GRP;

    typedef enum logic [1:0] {S_IDLE, S_GATHER, S_FINAL, S_OUT} t_state;

    t_state                  r_state;
    logic [CW-1:0]           r_count;
    logic [CMPW-1:0]         r_rd_pos;
    logic [VALUE_WIDTH-1:0]  r_grp [NGRP];
    logic signed [READ_W-1:0] r_read_value;
    logic [STATUS_W-1:0]     r_status;
    logic                    r_valid;

    logic                    w_accept;
    logic [CMPW-1:0]         w_p;
    logic [CMPW-1:0]         w_c;
    logic                    w_full;
    t_cell_cmd               w_cmd;
    logic [CMPW-1:0]         w_ins_pos;
    logic                    w_get;
    logic [STATUS_W-1:0]     w_status;
    logic [VALUE_WIDTH-1:0]  w_new;
    logic [VALUE_WIDTH-1:0]  w_val [CAPACITY];
    logic [VALUE_WIDTH-1:0]  w_sel [NGRP*GRP];
    logic [VALUE_WIDTH-1:0]  n_grp [NGRP];
    logic [VALUE_WIDTH-1:0]  n_final;

    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && !o_stall;
    assign w_p      = CMPW'(i_position);
    assign w_c      = CMPW'(r_count);
    assign w_full   = (r_count == CW'(CAPACITY));
    assign w_new    = VALUE_WIDTH'(i_item_value);

    always_comb begin
        w_cmd     = '0;
        w_ins_pos = w_p;
        w_get     = 1'b0;
        w_status  = ST_DONE;
        unique case (i_req_type)
            REQ_GET: begin
                if (w_p < w_c) begin
                    w_get = 1'b1;
                end else begin
                    w_status = ST_RANGE;
                end
            end
            REQ_INS_HEAD: begin
                w_ins_pos = '0;
                if (w_full) w_status = ST_FULL;
                else        w_cmd.ins = w_accept;
            end
            REQ_INS_TAIL: begin
                w_ins_pos = w_c;
                if (w_full) w_status = ST_FULL;
                else        w_cmd.ins = w_accept;
            end
            REQ_INS_BEFORE: begin
                if (w_p > w_c)   w_status = ST_RANGE;
                else if (w_full) w_status = ST_FULL;
                else             w_cmd.ins = w_accept;
            end
            REQ_DELETE: begin
                if (w_p >= w_c) w_status = ST_RANGE;
                else            w_cmd.del = w_accept;
            end
            default: w_status = ST_RANGE;
        endcase
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [VALUE_WIDTH-1:0] w_left;
        logic [VALUE_WIDTH-1:0] w_right;
        if (i == 0) begin : g_first
            assign w_left = w_new;
        end else begin : g_mid_l
            assign w_left = w_val[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign w_right = w_val[i];
        end else begin : g_mid_r
            assign w_right = w_val[i+1];
        end
        ilist_cell #(
            .IDX         (i),
            .CMPW        (CMPW),
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .i_clk    (i_clk),
            .i_cmd    (w_cmd),
            .i_pos    (w_ins_pos),
            .i_rd_pos (r_rd_pos),
            .i_new    (w_new),
            .i_left   (w_left),
            .i_right  (w_right),
            .o_value  (w_val[i]),
            .o_sel    (w_sel[i])
        );
    end

    for (genvar i = CAPACITY; i < NGRP*GRP; i++) begin : g_pad
        assign w_sel[i] = '0;
    end

    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_grp[g] = '0;
            for (int k = 0; k < GRP; k++) begin
                n_grp[g] = n_grp[g] | w_sel[g*GRP + k];
            end
        end
        n_final = '0;
        for (int g = 0; g < NGRP; g++) begin
            n_final = n_final | r_grp[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_rd_pos     <= w_p;
                        r_status     <= w_status;
                        r_read_value <= '1;
                        if (w_cmd.ins) r_count <= r_count + CW'(1);
                        if (w_cmd.del) r_count <= r_count - CW'(1);
                        if (w_get) begin
                            r_state <= S_GATHER;
                        end else begin
                            r_state <= S_OUT;
                            r_valid <= 1'b1;
                        end
                    end
                end
                S_GATHER: begin
                    r_grp   <= n_grp;
                    r_state <= S_FINAL;
                end
                S_FINAL: begin
                    r_read_value <= READ_W'(n_final);
                    r_valid      <= 1'b1;
                    r_state      <= S_OUT;
                end
                S_OUT: begin
                    // drop the result once it transfers
                    if (!i_stall) begin
                        r_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid      = r_valid;
    assign o_read_value = r_read_value;
    assign o_status     = r_status;
    assign o_length     = r_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("list count above capacity");

    a_ins_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.ins |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the list");

    a_del_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.del |=> (r_count == $past(r_count) - CW'(1)))
        else $error("delete did not shrink the list");

    a_busy_when_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("request taken while result pending");

    a_fail_no_edit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_status != ST_DONE)) |-> !(w_cmd.ins || w_cmd.del))
        else $error("failed request edited the list");

endmodule

@@ rtl/ilist_cell.sv @@
module ilist_cell #(
    parameter int IDX         = 0,
    parameter int CMPW        = 7,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  ilist_pkg::t_cell_cmd   i_cmd,
    input  logic [CMPW-1:0]        i_pos,
    input  logic [CMPW-1:0]        i_rd_pos,
    input  logic [VALUE_WIDTH-1:0] i_new,
    input  logic [VALUE_WIDTH-1:0] i_left,
    input  logic [VALUE_WIDTH-1:0] i_right,
    output logic [VALUE_WIDTH-1:0] o_value,
    output logic [VALUE_WIDTH-1:0] o_sel
);
    import ilist_pkg::*;

    localparam logic [CMPW-1:0] K = CMPW'(IDX);

    logic [VALUE_WIDTH-1:0] r_value;

    // insert: cells above the slot take the left neighbor; delete: pull from the right
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins) begin
            if (K > i_pos) begin
                r_value <= i_left;
            end else if (K == i_pos) begin
                r_value <= i_new;
            end
        end else if (i_cmd.del && (K >= i_pos)) begin
            r_value <= i_right;
        end
    end

    assign o_value = r_value;
    assign o_sel   = (K == i_rd_pos) ? r_value : '0;

endmodule

@@ tb/sv/indexed_list_engine_top_tb.sv @@
`timescale 1ns / 1ps

module indexed_list_engine_top_tb;

    import ilist_pkg::*;

    localparam int CAPACITY    = 64;
    localparam int LEN_W       = $clog2(CAPACITY + 1);
    localparam int N_DIRECTED  = 21;
    localparam int N_RANDOM    = 1600;
    localparam int CHUNK       = 96;

    // request codes the block does not implement
    localparam logic [REQ_W-1:0] REQ_RSVD_LO = 3'd5;
    localparam logic [REQ_W-1:0] REQ_RSVD_MID = 3'd6;
    localparam logic [REQ_W-1:0] REQ_RSVD_HI = 3'd7;

    typedef struct packed {
        logic [READ_W-1:0]   rd;
        logic [STATUS_W-1:0] st;
        logic [LEN_W-1:0]    len;
    } t_list_result;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic [POS_W-1:0] pos;
        logic [31:0]      val;
        logic             typed;
        t_list_result     res;
    } t_list_row;

    typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIX} t_mix_mode;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_valid      = 1'b0;
    logic                 o_stall;
    logic [REQ_W-1:0]     i_req_type   = '0;
    logic [POS_W-1:0]     i_position   = '0;
    logic signed [31:0]   i_item_value = '0;
    logic                 o_valid;
    logic                 i_stall      = 1'b0;
    logic signed [READ_W-1:0] o_read_value;
    logic [STATUS_W-1:0]  o_status;
    logic [LEN_W-1:0]     o_length;

    indexed_list_engine_top #(
        .CAPACITY   (CAPACITY),
        .VALUE_WIDTH(32)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_req_type  (i_req_type),
        .i_position  (i_position),
        .i_item_value(i_item_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_read_value(o_read_value),
        .o_status    (o_status),
        .o_length    (o_length)
    );

    always #5 i_clk = ~i_clk;

    logic [31:0]  list_mem [CAPACITY];
    int           list_len;
    t_list_result pending_results [$];
    t_list_result oldest;
    int           bad_results = 0;
    int           stall_left = 0;
    bit           quiet;
    int           n_sent, n_read_hits, n_range, n_full, peak_len;

    t_list_row directed_rows [N_DIRECTED] = '{
        '{REQ_GET,        7'd0,   32'd0,         1'b1, '{32'hFFFF_FFFF, ST_RANGE, 7'd0}},
        '{REQ_DELETE,     7'd0,   32'd0,         1'b1, '{32'hFFFF_FFFF, ST_RANGE, 7'd0}},
        '{REQ_INS_BEFORE, 7'd1,   32'd5,         1'b1, '{32'hFFFF_FFFF, ST_RANGE, 7'd0}},
        '{REQ_RSVD_LO,    7'd0,   32'd9,         1'b1, '{32'hFFFF_FFFF, ST_RANGE, 7'd0}},
        '{REQ_RSVD_HI,    7'd127, 32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, ST_RANGE, 7'd0}},
        '{REQ_INS_TAIL,   7'd0,   32'h7FFF_FFFF, 1'b1, '{32'hFFFF_FFFF, ST_DONE,  7'd1}},
        '{REQ_INS_HEAD,   7'd127, 32'h8000_0000, 1'b1, '{32'hFFFF_FFFF, ST_DONE,  7'd2}},
        '{REQ_GET,        7'd0,   32'd0,         1'b1, '{32'h8000_0000, ST_DONE,  7'd2}},
        '{REQ_GET,        7'd1,   32'd0,         1'b1, '{32'h7FFF_FFFF, ST_DONE,  7'd2}},
        '{REQ_GET,        7'd2,   32'd0,         1'b1, '{32'hFFFF_FFFF, ST_RANGE, 7'd2}},
        '{REQ_INS_BEFORE, 7'd2,   32'd0,         1'b1, '{32'hFFFF_FFFF, ST_DONE,  7'd3}},
        '{REQ_GET,        7'd2,   32'd0,         1'b1, '{32'h0000_0000, ST_DONE,  7'd3}},
        '{REQ_INS_BEFORE, 7'd1,   32'hFFFF_FFFF, 1'b0, '0},
        '{REQ_GET,        7'd1,   32'd0,         1'b0, '0},
        '{REQ_INS_BEFORE, 7'd5,   32'd7,         1'b1, '{32'hFFFF_FFFF, ST_RANGE, 7'd4}},
        '{REQ_DELETE,     7'd127, 32'd0,         1'b1, '{32'hFFFF_FFFF, ST_RANGE, 7'd4}},
        '{REQ_DELETE,     7'd0,   32'd0,         1'b0, '0},
        '{REQ_GET,        7'd0,   32'd0,         1'b0, '0},
        '{REQ_DELETE,     7'd2,   32'd0,         1'b0, '0},
        '{REQ_GET,        7'd1,   32'd0,         1'b0, '0},
        '{REQ_RSVD_MID,   7'd64,  32'd3,         1'b0, '0}
    };

    // mostly back to back, some short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // apply one request to the shadow list and return the result it yields
    function automatic t_list_result apply_to_list(input logic [REQ_W-1:0] req,
                                                   input int pos, input logic [31:0] val);
        t_list_result r;
        int k;
        r.rd = '1;
        r.st = ST_DONE;
        case (req)
            REQ_GET: begin
                if (pos < list_len)
                    r.rd = list_mem[pos];
                else
                    r.st = ST_RANGE;
            end
            REQ_INS_HEAD, REQ_INS_TAIL, REQ_INS_BEFORE: begin
                k = (req == REQ_INS_HEAD) ? 0 : (req == REQ_INS_TAIL) ? list_len : pos;
                // range check wins over the full check
                if (k > list_len)
                    r.st = ST_RANGE;
                else if (list_len >= CAPACITY)
                    r.st = ST_FULL;
                else begin
                    for (int i = list_len; i > k; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[k] = val;
                    list_len++;
                end
            end
            REQ_DELETE: begin
                if (pos >= list_len)
                    r.st = ST_RANGE;
                else begin
                    for (int i = pos; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            end
            default: r.st = ST_RANGE;
        endcase
        r.len = list_len[LEN_W-1:0];
        return r;
    endfunction

    // call right after a rising edge; returns at the edge of the transfer
    task automatic send_req(input logic [REQ_W-1:0] req, input logic [POS_W-1:0] pos,
                            input logic [31:0] val, input logic use_typed,
                            input t_list_result typed);
        t_list_result pred;
        int g;
        g = quiet ? 0 : gap_len();
        @(negedge i_clk);
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_req_type   <= req;
        i_position   <= pos;
        i_item_value <= val;
        forever begin
            @(posedge i_clk);
            if (!o_stall)
                break;
        end
        pred = apply_to_list(req, int'(pos), val);
        pending_results.push_back(use_typed ? typed : pred);
        n_sent++;
        if (req == REQ_GET && pred.st == ST_DONE)
            n_read_hits++;
        if (pred.st == ST_RANGE)
            n_range++;
        if (pred.st == ST_FULL)
            n_full++;
        if (list_len > peak_len)
            peak_len = list_len;
    endtask

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
            if (!quiet)
                stall_left = gap_len();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: read_value %h status %0d length %0d",
                       o_read_value, o_status, o_length);
                bad_results++;
            end else begin
                oldest = pending_results.pop_front();
                if (o_read_value !== oldest.rd) begin
                    $error("read_value: expected %h, got %h", oldest.rd, o_read_value);
                    bad_results++;
                end
                if (o_status !== oldest.st) begin
                    $error("status: expected %0d, got %0d", oldest.st, o_status);
                    bad_results++;
                end
                if (o_length !== oldest.len) begin
                    $error("length: expected %0d, got %0d", oldest.len, o_length);
                    bad_results++;
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("** indexed_list_engine_top: FAILED **");
        $finish;
    end

    initial begin
        t_mix_mode    mode;
        int           r, ins_pct, del_pct, p;
        logic [REQ_W-1:0] req;
        logic [31:0]  val;

        list_len = 0;
        quiet = 1'b0;
        n_sent = 0;
        n_read_hits = 0;
        n_range = 0;
        n_full = 0;
        peak_len = 0;
        mode = MODE_FILL;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[n])
            send_req(directed_rows[n].req, directed_rows[n].pos, directed_rows[n].val,
                     directed_rows[n].typed, directed_rows[n].res);

        for (int n = 0; n < N_RANDOM; n++) begin
            // pick a traffic mix per chunk; start by filling the list up
            if (n % CHUNK == 0) begin
                if (n != 0)
                    mode = t_mix_mode'($urandom_range(0, 2));
                quiet = ($urandom_range(0, 3) == 0);
            end
            case (mode)
                MODE_FILL:  begin ins_pct = 80; del_pct = 7;  end
                MODE_DRAIN: begin ins_pct = 12; del_pct = 60; end
                default:    begin ins_pct = 35; del_pct = 30; end
            endcase

            r = $urandom_range(0, 99);
            if (r < 3)
                req = REQ_W'($urandom_range(REQ_RSVD_HI, REQ_RSVD_LO));
            else if (r < 3 + ins_pct)
                req = REQ_W'($urandom_range(REQ_INS_BEFORE, REQ_INS_HEAD));
            else if (r < 3 + ins_pct + del_pct)
                req = REQ_DELETE;
            else
                req = REQ_GET;

            r = $urandom_range(0, 99);
            if (r < 75)
                p = $urandom_range(0, list_len);
            else if (r < 85)
                p = list_len + $urandom_range(0, 1);
            else
                p = $urandom_range(0, 127);

            if ($urandom_range(0, 9) == 0) begin
                case ($urandom_range(0, 3))
                    0: val = 32'h0000_0000;
                    1: val = 32'hFFFF_FFFF;
                    2: val = 32'h8000_0000;
                    default: val = 32'h7FFF_FFFF;
                endcase
            end else
                val = $urandom;

            send_req(req, p[POS_W-1:0], val, 1'b0, '0);
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        // let any stray result show up
        repeat (20) @(posedge i_clk);

        $display("ran %0d requests: %0d reads returned data, %0d out-of-range rejects,",
                 n_sent, n_read_hits, n_range);
        $display("%0d full-list rejects, list length peaked at %0d", n_full, peak_len);
        if (bad_results == 0)
            $display("** indexed_list_engine_top: PASSED **");
        else
            $display("** indexed_list_engine_top: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/ilist_pkg.sv
rtl/ilist_cell.sv
rtl/indexed_list_engine_top.sv
tb/sv/indexed_list_engine_top_tb.sv
